FILE: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Check an implication in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

FILE: sv/paa_pkg.sv
package paa_pkg;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int ACTIVE_DEPTH_DEF = 16;
  localparam int SLOT_NAMES       = 16;
  localparam logic [27:0] DUR_SUM_MAX = 28'hFFFFFFF;
  localparam logic [11:0] SM_SUM_MAX  = 12'hFFF;

  typedef enum logic [1:0] {
    ACT_SUBMIT = 2'd0,
    ACT_DONE   = 2'd1,
    ACT_POLL   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    RSN_IDLE    = 3'd0,
    RSN_HP      = 3'd1,
    RSN_COMP    = 3'd2,
    RSN_NO_HP   = 3'd3,
    RSN_UNPROF  = 3'd4,
    RSN_BLOCKED = 3'd5
  } reason_t;

  typedef enum logic [1:0] {
    CFG_PROFILED = 2'd0,
    CFG_MAX_DUR  = 2'd1,
    CFG_SM_COUNT = 2'd2,
    CFG_GATE     = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DECIDE,
    ST_COMMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        client;
    logic [7:0]  request_tag;
    logic [1:0]  kernel_class;
    logic [7:0]  sm_needed;
    logic [23:0] run_duration;
    logic [3:0]  done_slot;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic       granted;
    logic       grant_client;
    logic [7:0] grant_tag;
    logic [3:0] grant_slot;
    logic [2:0] grant_reason;
    logic       was_reordered;
  } rsp_t;

  typedef struct packed {
    logic        profiled_mode;
    logic [27:0] max_be_duration;
    logic [7:0]  device_sm_count;
    logic [1:0]  initial_gate_count;
  } cfg_t;
endpackage

FILE: sv/paa_if.sv
interface paa_req_if;
  logic          valid;
  logic          ready;
  paa_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface paa_rsp_if;
  logic          valid;
  logic          ready;
  paa_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/paa_front.sv
// Accept items into a two-entry queue toward the engine.
module paa_front (
  input  logic           clk,
  input  logic           rst,
  paa_req_if.sink        req,
  output logic           q_valid,
  output paa_pkg::req_t  q_data,
  input  logic           q_pop
);
  paa_pkg::req_t buf0, buf1;
  logic [1:0] cnt;

  assign req.ready = (cnt != 2'd2);
  assign q_valid   = (cnt != 2'd0);
  assign q_data    = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      if (req.valid && req.ready && !(q_pop && q_valid)) cnt <= cnt + 2'd1;
      else if (!(req.valid && req.ready) && q_pop && q_valid) cnt <= cnt - 2'd1;
    end
    if (q_pop && q_valid) begin
      if (req.valid && req.ready && cnt == 2'd1) buf0 <= req.data;
      else buf0 <= buf1;
    end else if (req.valid && req.ready) begin
      if (cnt == 2'd0) buf0 <= req.data;
      else buf1 <= req.data;
    end
  end
endmodule

FILE: sv/paa_engine.sv
// Execute submit, completion and poll items one at a time.
module paa_engine #(
  parameter int QUEUE_DEPTH  = paa_pkg::QUEUE_DEPTH_DEF,
  parameter int ACTIVE_DEPTH = paa_pkg::ACTIVE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  paa_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  paa_pkg::req_t q_data,
  output logic          q_pop,
  paa_rsp_if.source     rsp
);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(ACTIVE_DEPTH);
  localparam int AN = (ACTIVE_DEPTH < paa_pkg::SLOT_NAMES) ? ACTIVE_DEPTH
                                                           : paa_pkg::SLOT_NAMES;
  // entry: tag, class, sm, duration, arrival
  localparam int EW = 8 + 2 + 8 + 24 + 16;

  logic [EW-1:0] qmem [2][QUEUE_DEPTH];
  logic [QW-1:0] head [2];
  logic [CW-1:0] count [2];

  logic          a_valid [ACTIVE_DEPTH];
  logic          a_client [ACTIVE_DEPTH];
  logic [1:0]    a_cls [ACTIVE_DEPTH];
  logic [7:0]    a_sm [ACTIVE_DEPTH];
  logic [23:0]   a_dur [ACTIVE_DEPTH];
  logic [15:0]   a_stamp [ACTIVE_DEPTH];

  logic [11:0] be_sm_sum;
  logic [27:0] be_duration_sum;
  logic [15:0] arrival_counter, insert_stamp;
  logic        gate_open;

  paa_pkg::state_t state, state_next;
  paa_pkg::req_t   cur;
  paa_pkg::rsp_t   res;
  logic [EW-1:0]   hp_head, be_head;
  logic [AW:0]     idx;
  logic            h_found, f_found;
  logic [15:0]     h_age;
  logic [1:0]      h_cls;
  logic [AW-1:0]   f_slot;

  logic [AW-1:0] ix;
  assign ix = idx[AW-1:0];

  logic          cl;
  logic [EW-1:0] sel;
  assign cl  = (count[1] != '0);
  assign sel = cl ? hp_head : be_head;

  logic [1:0] nonempty;
  assign nonempty = {1'b0, count[1] != '0} + {1'b0, count[0] != '0};

  assign q_pop     = (state == paa_pkg::ST_IDLE) && q_valid;
  assign rsp.valid = (state == paa_pkg::ST_OUT);
  assign rsp.data  = res;

  always_comb begin
    state_next = state;
    unique case (state)
      paa_pkg::ST_IDLE:   if (q_valid) state_next = paa_pkg::ST_READ;
      paa_pkg::ST_READ:   state_next = (cur.action == paa_pkg::ACT_POLL) ? paa_pkg::ST_SCAN
                                                                         : paa_pkg::ST_COMMIT;
      paa_pkg::ST_SCAN:   if (idx == (AW+1)'(ACTIVE_DEPTH - 1)) state_next = paa_pkg::ST_DECIDE;
      paa_pkg::ST_DECIDE: state_next = paa_pkg::ST_COMMIT;
      paa_pkg::ST_COMMIT: state_next = paa_pkg::ST_OUT;
      paa_pkg::ST_OUT:    if (rsp.ready) state_next = paa_pkg::ST_IDLE;
      default:            state_next = paa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= paa_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Queue heads registered from memory.
  always_ff @(posedge clk) begin
    hp_head <= qmem[1][head[1]];
    be_head <= qmem[0][head[0]];
  end

  logic [QW:0]   wpos_w;
  logic [QW-1:0] wpos;
  logic [12:0]   fit_sum;
  logic          comp;
  always_comb begin
    wpos_w = {1'b0, head[cur.client]} + (QW+1)'(count[cur.client]);
    if (wpos_w >= (QW+1)'(QUEUE_DEPTH)) wpos_w = wpos_w - (QW+1)'(QUEUE_DEPTH);
    wpos = wpos_w[QW-1:0];
    fit_sum = {1'b0, be_sm_sum} + {5'd0, sel[47:40]};
    comp = (h_cls == 2'b11) || (sel[49:48] == 2'b11) || (h_cls != sel[49:48]);
  end

  logic [28:0] dsum;
  logic [12:0] ssum;
  always_comb begin
    dsum = {1'b0, be_duration_sum} + {5'd0, sel[39:16]};
    ssum = {1'b0, be_sm_sum} + {5'd0, sel[47:40]};
  end

  // Poll decision from the scan results and the queue heads.
  logic             dec_grant, dec_reord;
  paa_pkg::reason_t dec_reason;
  always_comb begin
    dec_grant  = 1'b0;
    dec_reord  = 1'b0;
    dec_reason = paa_pkg::RSN_IDLE;
    if ((gate_open || {1'b0, nonempty} >= {1'b0, cfg.initial_gate_count})
        && nonempty != 2'd0) begin
      dec_grant = 1'b1;
      if (cl) begin
        if (cfg.profiled_mode) dec_reason = paa_pkg::RSN_HP;
        else dec_reason = paa_pkg::RSN_UNPROF;
        dec_reord = (count[0] != '0) && (be_head[15:0] != hp_head[15:0]) &&
                    ((hp_head[15:0] - be_head[15:0]) < 16'h8000);
      end else if (!cfg.profiled_mode) begin
        dec_reason = paa_pkg::RSN_UNPROF;
      end else if (!h_found) begin
        dec_reason = paa_pkg::RSN_NO_HP;
      end else if (be_duration_sum > cfg.max_be_duration || !comp ||
                   fit_sum > {5'd0, cfg.device_sm_count}) begin
        dec_grant  = 1'b0;
        dec_reason = paa_pkg::RSN_BLOCKED;
      end else begin
        dec_reason = paa_pkg::RSN_COMP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        head[c]  <= '0;
        count[c] <= '0;
      end
      for (int i = 0; i < ACTIVE_DEPTH; i++) a_valid[i] <= 1'b0;
      be_sm_sum <= '0;
      be_duration_sum <= '0;
      arrival_counter <= '0;
      insert_stamp <= '0;
      gate_open <= 1'b0;
    end else begin
      unique case (state)
        paa_pkg::ST_IDLE: begin
          if (q_valid) cur <= q_data;
          res <= '0;
          idx <= '0;
          h_found <= 1'b0;
          f_found <= 1'b0;
        end
        paa_pkg::ST_SCAN: begin
          // one active entry per cycle: latest high-priority and lowest free slot
          if (a_valid[ix] && a_client[ix] &&
              (!h_found || (insert_stamp - a_stamp[ix]) < h_age)) begin
            h_found <= 1'b1;
            h_age   <= insert_stamp - a_stamp[ix];
            h_cls   <= a_cls[ix];
          end
          if (!a_valid[ix] && !f_found && idx < (AW+1)'(AN)) begin
            f_found <= 1'b1;
            f_slot  <= ix;
          end
          idx <= idx + 1'b1;
        end
        paa_pkg::ST_DECIDE: begin
          res.granted       <= dec_grant;
          res.grant_reason  <= dec_reason;
          res.was_reordered <= dec_reord;
          if (!gate_open && {1'b0, nonempty} >= {1'b0, cfg.initial_gate_count})
            gate_open <= 1'b1;
        end
        paa_pkg::ST_COMMIT: begin
          if (cur.action == paa_pkg::ACT_SUBMIT) begin
            if (count[cur.client] < CW'(QUEUE_DEPTH)) begin
              qmem[cur.client][wpos] <= {cur.request_tag, cur.kernel_class,
                                         cur.sm_needed, cur.run_duration, arrival_counter};
              arrival_counter <= arrival_counter + 16'd1;
              count[cur.client] <= count[cur.client] + 1'b1;
              res.accepted <= 1'b1;
            end
          end else if (cur.action == paa_pkg::ACT_DONE) begin
            if (32'(cur.done_slot) < 32'(ACTIVE_DEPTH) &&
                a_valid[AW'(cur.done_slot)]) begin
              if (!a_client[AW'(cur.done_slot)]) begin
                be_sm_sum <= (be_sm_sum >= {4'd0, a_sm[AW'(cur.done_slot)]}) ?
                             be_sm_sum - {4'd0, a_sm[AW'(cur.done_slot)]} : '0;
                be_duration_sum <= (be_duration_sum >= {4'd0, a_dur[AW'(cur.done_slot)]}) ?
                             be_duration_sum - {4'd0, a_dur[AW'(cur.done_slot)]} : '0;
              end
              a_valid[AW'(cur.done_slot)] <= 1'b0;
              res.accepted <= 1'b1;
            end
          end else if (cur.action == paa_pkg::ACT_POLL && res.granted) begin
            if (cfg.profiled_mode && !f_found) begin
              res.granted <= 1'b0;
              res.grant_reason <= paa_pkg::RSN_BLOCKED;
              res.was_reordered <= 1'b0;
            end else begin
              res.grant_client <= cl;
              res.grant_tag <= sel[57:50];
              res.grant_slot <= cfg.profiled_mode ? 4'(f_slot) : 4'd0;
              if (cfg.profiled_mode) begin
                a_valid[f_slot]  <= 1'b1;
                a_client[f_slot] <= cl;
                a_cls[f_slot]    <= sel[49:48];
                a_sm[f_slot]     <= sel[47:40];
                a_dur[f_slot]    <= sel[39:16];
                a_stamp[f_slot]  <= insert_stamp + 16'd1;
                insert_stamp     <= insert_stamp + 16'd1;
                if (!cl) begin
                  be_sm_sum <= ssum > {1'b0, paa_pkg::SM_SUM_MAX} ?
                               paa_pkg::SM_SUM_MAX : ssum[11:0];
                  be_duration_sum <= dsum > {1'b0, paa_pkg::DUR_SUM_MAX} ?
                               paa_pkg::DUR_SUM_MAX : dsum[27:0];
                end
              end
              head[cl] <= (head[cl] == QW'(QUEUE_DEPTH - 1)) ? '0 : head[cl] + 1'b1;
              count[cl] <= count[cl] - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: sv/priority_admission_arbiter.sv
// Flow: a submit or completion item passes the read, commit and output states; a
// poll also passes the scan, one active entry per cycle, and the decide state.
// The engine takes a new item only after the last result is taken, and a result
// waits in the output state for ready; the input queue holds two items.
// Reset: rst is synchronous, active high; queues empty, active table invalid,
// sums, counters and gate cleared, registers back to 0, 16000, 16, 0.
module priority_admission_arbiter #(
  parameter int QUEUE_DEPTH  = paa_pkg::QUEUE_DEPTH_DEF,
  parameter int ACTIVE_DEPTH = paa_pkg::ACTIVE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  paa_req_if.sink     in_ch,
  paa_rsp_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [27:0] cfg_data
);
  paa_pkg::cfg_t cfg;
  logic          q_valid, q_pop;
  paa_pkg::req_t q_data;

  // Hold configuration; to be written only while idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.profiled_mode      <= 1'b0;
      cfg.max_be_duration    <= 28'd16000;
      cfg.device_sm_count    <= 8'd16;
      cfg.initial_gate_count <= 2'd0;
    end else if (cfg_we) begin
      unique case (paa_pkg::cfg_idx_t'(cfg_index))
        paa_pkg::CFG_PROFILED: cfg.profiled_mode      <= cfg_data[0];
        paa_pkg::CFG_MAX_DUR:  cfg.max_be_duration    <= cfg_data;
        paa_pkg::CFG_SM_COUNT: cfg.device_sm_count    <= cfg_data[7:0];
        paa_pkg::CFG_GATE:     cfg.initial_gate_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Front: accept and buffer items.
  paa_front u_front (
    .clk(clk), .rst(rst), .req(in_ch),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  // Back: carry out each item and present its result.
  paa_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .ACTIVE_DEPTH(ACTIVE_DEPTH)) u_engine (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .rsp(out_ch)
  );
endmodule

FILE: sv/paa_checker.sv
`include "assert_macros.svh"
module paa_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input paa_pkg::rsp_t out_data
);
  `ASSERT_IMPL(a_grant_no_accept, clk, rst, out_valid && out_data.granted, !out_data.accepted, "grant with accepted")
  `ASSERT_IMPL(a_reason_range, clk, rst, out_valid, out_data.grant_reason <= paa_pkg::RSN_BLOCKED, "bad reason")
  `ASSERT_IMPL(a_nogrant_zero, clk, rst, out_valid && !out_data.granted, !out_data.was_reordered && out_data.grant_tag == 8'd0, "fields without grant")
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
endmodule

bind priority_admission_arbiter paa_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);

FILE: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QD = paa_pkg::QUEUE_DEPTH_DEF;
  localparam int AD = paa_pkg::ACTIVE_DEPTH_DEF;
  // Longest item latency: a poll scans the whole active table.
  localparam int POLL_CYCLES = AD + 5;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [27:0] cfg_data;

  paa_req_if req_ch();
  paa_rsp_if rsp_ch();

  priority_admission_arbiter uut (
    .clk(clk),
    .rst(rst),
    .in_ch(req_ch),
    .out_ch(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the arbiter: request FIFOs, active table, sums and registers.
  typedef struct {
    logic [7:0]  tag;
    logic [1:0]  cls;
    logic [7:0]  sm;
    logic [23:0] dur;
    logic [15:0] arrival;
  } queued_req_t;

  typedef struct {
    bit          valid;
    bit          client;
    logic [1:0]  cls;
    logic [7:0]  sm;
    logic [23:0] dur;
    logic [15:0] stamp;
  } active_op_t;

  queued_req_t fifo_mem [2][QD];
  int          fifo_head [2];
  int          fifo_cnt [2];
  active_op_t  ops [AD];
  logic [11:0] be_sms;
  logic [27:0] be_time;
  logic [15:0] arrival_ctr;
  logic [15:0] grant_stamp;
  bit          gate_is_open;

  bit          mode_profiled;
  logic [27:0] be_time_limit;
  logic [7:0]  sm_total;
  logic [1:0]  gate_need;

  paa_pkg::req_t pending_items [$];
  paa_pkg::rsp_t expected_grants [$];
  bit            failed;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned mon_cycle;
  int unsigned stall_mode;

  // Older-than test with 16-bit wraparound.
  function automatic bit arrived_first(logic [15:0] a, logic [15:0] b);
    logic [15:0] diff;
    diff = b - a;
    return (a != b) && (diff < 16'h8000);
  endfunction

  // Work out the answer to one item and advance the shadow state.
  function automatic paa_pkg::rsp_t admit(paa_pkg::req_t r);
    paa_pkg::rsp_t    o;
    int               pos;
    int               cl;
    int               hp;
    int               slot;
    int               nonempty;
    bit               comp;
    bit               fits;
    bit               reord;
    paa_pkg::reason_t why;
    queued_req_t      head_req;
    logic [15:0]      age;
    logic [15:0]      best_age;
    longint           sum;
    o = '0;
    reord = 1'b0;
    case (paa_pkg::action_t'(r.action))
      paa_pkg::ACT_SUBMIT: begin
        if (fifo_cnt[r.client] < QD) begin
          pos = (fifo_head[r.client] + fifo_cnt[r.client]) % QD;
          fifo_mem[r.client][pos] = '{r.request_tag, r.kernel_class, r.sm_needed,
                                      r.run_duration, arrival_ctr};
          arrival_ctr++;
          fifo_cnt[r.client]++;
          o.accepted = 1'b1;
        end
      end
      paa_pkg::ACT_DONE: begin
        if (r.done_slot < AD && ops[r.done_slot].valid) begin
          if (!ops[r.done_slot].client) begin
            be_sms  = (be_sms >= ops[r.done_slot].sm) ? be_sms - ops[r.done_slot].sm : '0;
            be_time = (be_time >= ops[r.done_slot].dur) ? be_time - ops[r.done_slot].dur : '0;
          end
          ops[r.done_slot].valid = 1'b0;
          o.accepted = 1'b1;
        end
      end
      paa_pkg::ACT_POLL: begin
        nonempty = (fifo_cnt[1] != 0) + (fifo_cnt[0] != 0);
        if (!gate_is_open) begin
          if (nonempty < gate_need) return o;
          gate_is_open = 1'b1;
        end
        if (nonempty == 0) return o;
        cl = (fifo_cnt[1] != 0) ? 1 : 0;
        head_req = fifo_mem[cl][fifo_head[cl]];
        slot = 0;
        if (cl == 1) begin
          why = mode_profiled ? paa_pkg::RSN_HP : paa_pkg::RSN_UNPROF;
          // A best-effort request that came first is passed over.
          if (fifo_cnt[0] != 0 &&
              arrived_first(fifo_mem[0][fifo_head[0]].arrival, head_req.arrival))
            reord = 1'b1;
        end else if (!mode_profiled) begin
          why = paa_pkg::RSN_UNPROF;
        end else begin
          hp = -1;
          best_age = '0;
          for (int i = 0; i < AD; i++) begin
            if (ops[i].valid && ops[i].client) begin
              age = grant_stamp - ops[i].stamp;
              if (hp < 0 || age < best_age) begin
                hp = i;
                best_age = age;
              end
            end
          end
          if (hp < 0) begin
            why = paa_pkg::RSN_NO_HP;
          end else begin
            comp = ops[hp].cls == 2'b11 || head_req.cls == 2'b11 || ops[hp].cls != head_req.cls;
            fits = (int'(be_sms) + int'(head_req.sm)) <= int'(sm_total);
            if (be_time > be_time_limit || !comp || !fits) begin
              o.grant_reason = paa_pkg::RSN_BLOCKED;
              return o;
            end
            why = paa_pkg::RSN_COMP;
          end
        end
        if (mode_profiled) begin
          slot = -1;
          for (int i = 0; i < AD && i < paa_pkg::SLOT_NAMES; i++)
            if (slot < 0 && !ops[i].valid) slot = i;
          if (slot < 0) begin
            o.grant_reason = paa_pkg::RSN_BLOCKED;
            return o;
          end
        end
        o.granted       = 1'b1;
        o.grant_client  = cl[0];
        o.grant_tag     = head_req.tag;
        o.grant_slot    = slot[3:0];
        o.grant_reason  = why;
        o.was_reordered = reord;
        if (mode_profiled) begin
          grant_stamp++;
          ops[slot] = '{1'b1, cl[0], head_req.cls, head_req.sm, head_req.dur, grant_stamp};
          if (cl == 0) begin
            sum = be_sms + head_req.sm;
            be_sms = (sum > paa_pkg::SM_SUM_MAX) ? paa_pkg::SM_SUM_MAX : sum[11:0];
            sum = be_time + head_req.dur;
            be_time = (sum > paa_pkg::DUR_SUM_MAX) ? paa_pkg::DUR_SUM_MAX : sum[27:0];
          end
        end
        fifo_head[cl] = (fifo_head[cl] + 1) % QD;
        fifo_cnt[cl]--;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Clock: 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Driver: offer items in bursts with random gaps; hold an item until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      // Predict at the edge the item is accepted.
      if (req_ch.valid && req_ch.ready)
        expected_grants.insert(expected_grants.size(), admit(req_ch.data));
      if (req_ch.valid && !req_ch.ready) begin
        // hold: the item stays on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= pending_items[0];
        pending_items.delete(0);
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          // Some bursts run back to back with no gap at all.
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left--;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest prediction; stall on a pattern.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      mon_cycle = 0;
      stall_mode = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_grants.size() == 0) begin
          $error("result with no item outstanding");
          failed = 1'b1;
        end else begin
          paa_pkg::rsp_t want;
          want = expected_grants[0];
          expected_grants.delete(0);
          check_field("accepted", want.accepted, rsp_ch.data.accepted);
          check_field("granted", want.granted, rsp_ch.data.granted);
          check_field("grant_client", want.grant_client, rsp_ch.data.grant_client);
          check_field("grant_tag", want.grant_tag, rsp_ch.data.grant_tag);
          check_field("grant_slot", want.grant_slot, rsp_ch.data.grant_slot);
          check_field("grant_reason", want.grant_reason, rsp_ch.data.grant_reason);
          check_field("was_reordered", want.was_reordered, rsp_ch.data.was_reordered);
        end
      end
      mon_cycle++;
      if (mon_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      // One long hold-off while the driver keeps offering, to back the block up.
      if (mon_cycle >= 6000 && mon_cycle < 6600)
        rsp_ch.ready <= 1'b0;
      else case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= mon_cycle[2];
      endcase
    end
  end

  task automatic write_reg(paa_pkg::cfg_idx_t idx, logic [27:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      paa_pkg::CFG_PROFILED: mode_profiled = value[0];
      paa_pkg::CFG_MAX_DUR:  be_time_limit = value;
      paa_pkg::CFG_SM_COUNT: sm_total      = value[7:0];
      default:               gate_need     = value[1:0];
    endcase
  endtask

  task automatic set_regs(bit prof, logic [27:0] limit, logic [7:0] sms, logic [1:0] gate);
    write_reg(paa_pkg::CFG_PROFILED, {27'd0, prof});
    write_reg(paa_pkg::CFG_MAX_DUR, limit);
    write_reg(paa_pkg::CFG_SM_COUNT, {20'd0, sms});
    write_reg(paa_pkg::CFG_GATE, {26'd0, gate});
  endtask

  task automatic add(paa_pkg::action_t act, bit client, logic [7:0] tag, logic [1:0] cls,
                     logic [7:0] sm, logic [23:0] dur, logic [3:0] slot);
    paa_pkg::req_t r;
    r.action       = act;
    r.client       = client;
    r.request_tag  = tag;
    r.kernel_class = cls;
    r.sm_needed    = sm;
    r.run_duration = dur;
    r.done_slot    = slot;
    pending_items.insert(pending_items.size(), r);
  endtask

  // Random item with the given odds (in percent) of submit, poll and completion.
  task automatic add_random(int p_sub, int p_poll, int p_done);
    int                roll;
    paa_pkg::action_t  act;
    roll = $urandom_range(0, 99);
    if (roll < p_sub) act = paa_pkg::ACT_SUBMIT;
    else if (roll < p_sub + p_poll) act = paa_pkg::ACT_POLL;
    else if (roll < p_sub + p_poll + p_done) act = paa_pkg::ACT_DONE;
    else act = paa_pkg::ACT_NONE;
    add(act, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
        8'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8)),
        24'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) :
            ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24'hFFFFFF) :
                                          $urandom_range(1, 20000)),
        4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5)));
  endtask

  // Wait until every item is sent and every result is back, then let the block settle.
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() > 0 || req_ch.valid || expected_grants.size() > 0);
    repeat (POLL_CYCLES + 8) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = paa_pkg::CFG_PROFILED;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    failed = 1'b0;
    fifo_head = '{0, 0};
    fifo_cnt = '{0, 0};
    foreach (ops[i]) ops[i] = '{1'b0, 1'b0, 2'b00, 8'd0, 24'd0, 16'd0};
    be_sms = '0;
    be_time = '0;
    arrival_ctr = '0;
    grant_stamp = '0;
    gate_is_open = 1'b0;
    mode_profiled = 1'b0;
    be_time_limit = 28'd16000;
    sm_total = 8'd16;
    gate_need = 2'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Unprofiled, gate needs both queues: gated polls, bad items, reordered grant.
    set_regs(1'b0, 28'd16000, 8'd16, 2'd2);
    add(paa_pkg::ACT_POLL, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_SUBMIT, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_POLL, 1'b1, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_NONE, 1'b1, 8'hFF, 2'b11, 8'hFF, 24'hFFFFFF, 4'hF);
    add(paa_pkg::ACT_DONE, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'hF);
    add(paa_pkg::ACT_SUBMIT, 1'b1, 8'hFF, 2'b11, 8'hFF, 24'hFFFFFF, 4'hF);
    add(paa_pkg::ACT_POLL, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_POLL, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_POLL, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    drain();

    // Profiled: high priority, blocked on same class, no active HP, compatible class, too many SMs.
    set_regs(1'b1, 28'd100, 8'd16, 2'd0);
    add(paa_pkg::ACT_SUBMIT, 1'b1, 8'h11, 2'b00, 8'd4, 24'd10, 4'd0);
    add(paa_pkg::ACT_POLL, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_SUBMIT, 1'b0, 8'h22, 2'b00, 8'd2, 24'd50, 4'd0);
    add(paa_pkg::ACT_POLL, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_DONE, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_POLL, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_SUBMIT, 1'b1, 8'h33, 2'b01, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_POLL, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_SUBMIT, 1'b0, 8'h44, 2'b10, 8'd5, 24'd60, 4'd0);
    add(paa_pkg::ACT_POLL, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_SUBMIT, 1'b0, 8'h55, 2'b11, 8'd200, 24'd1, 4'd0);
    add(paa_pkg::ACT_POLL, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_DONE, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd0);
    add(paa_pkg::ACT_DONE, 1'b0, 8'd0, 2'b00, 8'd1, 24'd1, 4'd1);
    drain();

    // Random phases across register settings, extremes included.
    set_regs(1'b1, 28'd16000, 8'd16, 2'd1);
    repeat (250) add_random(40, 40, 15);
    drain();
    set_regs(1'b1, 28'd1, 8'd1, 2'd0);
    repeat (250) add_random(35, 40, 20);
    drain();
    // Few completions: the active table fills and grants block.
    set_regs(1'b1, 28'hFFFFFFF, 8'd255, 2'd2);
    repeat (250) add_random(30, 55, 10);
    drain();
    // Submit-heavy: the request FIFOs overflow.
    set_regs(1'b0, 28'($urandom_range(1, 28'hFFFFFFF)), 8'($urandom_range(1, 255)), 2'd0);
    repeat (250) add_random(70, 25, 3);
    drain();
    set_regs(1'b1, 28'($urandom_range(1, 200000)), 8'($urandom_range(1, 64)), 2'd1);
    repeat (250) add_random(40, 40, 15);
    drain();

    if (!failed && expected_grants.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/paa_pkg.sv
sv/paa_if.sv
sv/paa_front.sv
sv/paa_engine.sv
sv/priority_admission_arbiter.sv
sv/paa_checker.sv
sim/tb.sv
